FILE: hdl/mt64_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mt64_pkg
// Shared constants, types and word functions of the 64-bit Mersenne Twister.
// ----------------------------------------------------------------------------
package mt64_pkg;

	localparam int unsigned STATE_WORDS  = 312;
	localparam int unsigned TWIST_OFFSET = 156;
	localparam int unsigned IDX_W        = $clog2(STATE_WORDS + 1);

	localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
	localparam logic [63:0] UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] SEED_MULT    = 64'd6364136223846793005;

	localparam logic [63:0] TEMPER_MASK_A = 64'h5555_5555_5555_5555;
	localparam logic [63:0] TEMPER_MASK_B = 64'h71D6_7FFF_EDA6_0000;
	localparam logic [63:0] TEMPER_MASK_C = 64'hFFF7_EEE0_0000_0000;

	typedef logic [63:0] word_t;
	typedef logic [IDX_W-1:0] idx_t;

	// Control handed from the seeding sequencer to the top level.
	typedef struct packed {
		logic shift;
		logic busy;
	} seed_ctl_t;

	typedef enum logic [2:0] {
		SEED_IDLE = 3'b001,
		SEED_MUL  = 3'b010,
		SEED_ADD  = 3'b100
	} seed_state_t;

	// One step of the recurrence: a new word from words i, i+1 and i+offset.
	function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
		word_t y;
		word_t v;
		y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TWIST_MATRIX;
		end
		return v;
	endfunction

	function automatic word_t temper(input word_t w);
		word_t x;
		x = w;
		x = x ^ ((x >> 29) & TEMPER_MASK_A);
		x = x ^ ((x << 17) & TEMPER_MASK_B);
		x = x ^ ((x << 37) & TEMPER_MASK_C);
		x = x ^ (x >> 43);
		return x;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/mt64_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mt64_cell
// One state word of the generator; loads the word at its input, its neighbour's or the new tail word, on a shift.
// ----------------------------------------------------------------------------
module mt64_cell (
	input  wire                  clk,
	input  wire                  shift_en,
	input  wire mt64_pkg::word_t d,
	output mt64_pkg::word_t      q
);

	mt64_pkg::word_t word_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule
`default_nettype wire

FILE: hdl/mt64_seeder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mt64_seeder
// Seeding sequencer: produces the initial state words one after another.
// ----------------------------------------------------------------------------
module mt64_seeder (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire mt64_pkg::word_t seed,
	input  wire mt64_pkg::word_t prev,
	output mt64_pkg::seed_ctl_t  ctl,
	output mt64_pkg::word_t      word
);

	mt64_pkg::seed_state_t state_q;
	mt64_pkg::idx_t        idx_q;
	logic [63:0]           pll_q;
	logic [31:0]           phl_q;
	logic [31:0]           plh_q;
	mt64_pkg::word_t       p;
	logic [31:0]           full_hl;
	logic [31:0]           full_lh;
	logic [31:0]           mid_sum;

	assign p       = prev ^ (prev >> 62);
	assign full_hl = p[63:32] * mt64_pkg::SEED_MULT[31:0];
	assign full_lh = p[31:0] * mt64_pkg::SEED_MULT[63:32];
	assign mid_sum = phl_q + plh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mt64_pkg::SEED_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				mt64_pkg::SEED_IDLE: begin
					if (start) begin
						state_q <= mt64_pkg::SEED_MUL;
						idx_q   <= mt64_pkg::idx_t'(1);
					end
				end
				mt64_pkg::SEED_MUL: begin
					state_q <= mt64_pkg::SEED_ADD;
				end
				mt64_pkg::SEED_ADD: begin
					if (idx_q == mt64_pkg::idx_t'(mt64_pkg::STATE_WORDS - 1)) begin
						state_q <= mt64_pkg::SEED_IDLE;
					end else begin
						state_q <= mt64_pkg::SEED_MUL;
						idx_q   <= idx_q + mt64_pkg::idx_t'(1);
					end
				end
				default: begin
					state_q <= mt64_pkg::SEED_IDLE;
				end
			endcase
		end
	end

	// The product is split into 32-bit partial products; only the low half
	// of the cross terms reaches the low 64 bits of the result.
	always_ff @(posedge clk) begin
		if (state_q == mt64_pkg::SEED_MUL) begin
			pll_q <= 64'(p[31:0]) * 64'(mt64_pkg::SEED_MULT[31:0]);
			phl_q <= full_hl;
			plh_q <= full_lh;
		end
	end

	always_comb begin
		ctl.busy  = (state_q != mt64_pkg::SEED_IDLE);
		ctl.shift = 1'b0;
		word      = seed;
		case (state_q)
			mt64_pkg::SEED_IDLE: begin
				ctl.shift = start;
				word      = seed;
			end
			mt64_pkg::SEED_ADD: begin
				ctl.shift = 1'b1;
				word      = pll_q + {mid_sum, 32'h0}
				          + {{(64 - mt64_pkg::IDX_W){1'b0}}, idx_q};
			end
			default: begin
				ctl.shift = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/mt64_random_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mt64_random_generator
// 64-bit Mersenne Twister (MT19937-64) on a streaming interface.
// ----------------------------------------------------------------------------
// The 312 state words sit in a row of cells that shifts by one word per draw
// or seeded word. A draw (tuser = 0) forms the next word from the head word,
// the one after it and the one 156 places on, shifts it into the tail and
// returns its tempered value in the next cycle; draws are taken one per cycle
// while no reseed runs and the output is free or being taken. A reseed
// (tuser = 1) gives no output transfer and keeps the block busy: the seed
// enters as it is accepted, then the sequencer takes a multiply and an add
// state per further word of its split 64-bit multiplication. The first transfer
// after reset must be a reseed; draws before it return undefined values.
module mt64_random_generator (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [63:0] s_axis_tdata,   // [63:0] seed_value
	input  wire         s_axis_tuser,   // [0] func (1 = reseed, 0 = draw)
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata    // [63:0] random_value
);

	mt64_pkg::word_t     cell_q [mt64_pkg::STATE_WORDS];
	mt64_pkg::word_t     cell_d [mt64_pkg::STATE_WORDS];
	mt64_pkg::seed_ctl_t seed_ctl;
	mt64_pkg::word_t     seed_word;
	mt64_pkg::word_t     new_word;
	mt64_pkg::word_t     tail_d;
	logic                accept;
	logic                draw;
	logic                start;
	logic                shift_en;
	logic                out_valid_q;
	mt64_pkg::word_t     out_data_q;

	assign s_axis_tready = !seed_ctl.busy && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign draw          = accept && !s_axis_tuser;
	assign start         = accept && s_axis_tuser;

	mt64_seeder u_seeder (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.seed   (s_axis_tdata),
		.prev   (cell_q[mt64_pkg::STATE_WORDS-1]),
		.ctl    (seed_ctl),
		.word   (seed_word)
	);

	assign new_word = mt64_pkg::twist_word(cell_q[0], cell_q[1],
	                                       cell_q[mt64_pkg::TWIST_OFFSET]);
	assign tail_d   = seed_ctl.shift ? seed_word : new_word;
	assign shift_en = draw || seed_ctl.shift;

	// Words move towards the head; the tail takes the newly made word.
	genvar k;
	generate
		for (k = 0; k < mt64_pkg::STATE_WORDS; k++) begin : g_cell
			if (k == mt64_pkg::STATE_WORDS - 1) begin : g_tail
				assign cell_d[k] = tail_d;
			end else begin : g_body
				assign cell_d[k] = cell_q[k+1];
			end
			mt64_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.d        (cell_d[k]),
				.q        (cell_q[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (draw) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw) begin
			out_data_q <= mt64_pkg::temper(new_word);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

FILE: test/mt64_random_generator_test.sv
// ----------------------------------------------------------------------------
// mt64_random_generator_test
// Self-checking bench for the 64-bit Mersenne Twister stream block.
// ----------------------------------------------------------------------------
// Reseed and draw transfers go in on the slave side. A local model of the
// generator keeps its own copy of the 312 state words and the read index, and
// works out the tempered word each accepted draw should return. Every output
// transfer is checked against the oldest outstanding word. A short table of
// directed items runs first, covering seed extremes, reseeds in the middle of a
// stream and back-to-back reseeds. Three random phases with different idling on
// each side follow, and the last phase draws far enough to regenerate the state
// three times while the output is held off for a long stretch.
module mt64_random_generator_test;

	typedef logic [63:0] word_t;

	typedef enum logic {
		FUNC_DRAW   = 1'b0,
		FUNC_RESEED = 1'b1
	} func_t;

	typedef struct packed {
		func_t func;
		word_t seed;
	} stim_t;

	localparam int unsigned N_WORDS     = 312;
	localparam int unsigned MID_OFFSET  = 156;
	localparam word_t       TWIST_POLY  = 64'hB502_6F5A_A966_19E9;
	localparam word_t       HIGH_BITS   = 64'hFFFF_FFFF_8000_0000;
	localparam word_t       LOW_BITS    = 64'h0000_0000_7FFF_FFFF;
	localparam word_t       INIT_MULT   = 64'd6364136223846793005;
	localparam word_t       TEMPER_B    = 64'h5555_5555_5555_5555;
	localparam word_t       TEMPER_C    = 64'h71D6_7FFF_EDA6_0000;
	localparam word_t       TEMPER_D    = 64'hFFF7_EEE0_0000_0000;

	localparam int unsigned HOLD_CYCLES = 300;   // long output hold-off
	localparam int unsigned TAIL_CYCLES = 700;   // longer than a reseed keeps the block busy
	localparam int unsigned N_DIRECTED  = 22;

	// On draws the seed field is ignored, so those rows carry patterns on it.
	localparam stim_t DIRECTED [N_DIRECTED] = '{
		'{FUNC_RESEED, 64'h0000_0000_0000_0000},
		'{FUNC_DRAW,   64'h0000_0000_0000_0000},
		'{FUNC_DRAW,   64'hFFFF_FFFF_FFFF_FFFF},
		'{FUNC_DRAW,   64'h0000_0000_0000_0000},
		'{FUNC_RESEED, 64'hFFFF_FFFF_FFFF_FFFF},
		'{FUNC_DRAW,   64'h0000_0000_0000_0000},
		'{FUNC_DRAW,   64'hA5A5_A5A5_A5A5_A5A5},
		'{FUNC_RESEED, 64'd5489},
		'{FUNC_DRAW,   64'h0000_0000_0000_0000},
		'{FUNC_DRAW,   64'h0000_0000_0000_0000},
		'{FUNC_DRAW,   64'h0000_0000_0000_0000},
		'{FUNC_RESEED, 64'h8000_0000_0000_0000},
		'{FUNC_RESEED, 64'h0000_0000_0000_0001},
		'{FUNC_DRAW,   64'h5A5A_5A5A_5A5A_5A5A},
		'{FUNC_RESEED, 64'h5555_5555_5555_5555},
		'{FUNC_DRAW,   64'h0000_0000_0000_0000},
		'{FUNC_DRAW,   64'hFFFF_FFFF_FFFF_FFFF},
		'{FUNC_RESEED, 64'hAAAA_AAAA_AAAA_AAAA},
		'{FUNC_DRAW,   64'h5555_5555_5555_5555},
		'{FUNC_DRAW,   64'h0000_0000_0000_0000},
		'{FUNC_RESEED, 64'h7FFF_FFFF_FFFF_FFFF},
		'{FUNC_DRAW,   64'h0000_0000_0000_0000}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	wire         s_axis_tready;
	logic [63:0] s_axis_tdata;    // [63:0] seed_value
	logic        s_axis_tuser;    // [0] func (1 = reseed, 0 = draw)
	wire         m_axis_tvalid;
	logic        m_axis_tready;
	wire  [63:0] m_axis_tdata;    // [63:0] random_value

	// Local generator state.
	word_t       gen_words [N_WORDS];
	int unsigned gen_index;

	word_t       draws_due [$];
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	bit          hold_request;
	int unsigned mismatches;
	int unsigned n_items;
	int unsigned n_reseeds;
	int unsigned n_checked;
	int unsigned n_regens;

	mt64_random_generator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 500_000);
		$display("%0t: timed out with %0d words outstanding", $time, draws_due.size());
		$display("** mt64_random_generator: FAILED **");
		$finish;
	end

	function automatic void load_seed(input word_t seed);
		word_t prev;
		int unsigned k;
		gen_words[0] = seed;
		for (k = 1; k < N_WORDS; k++) begin
			prev = gen_words[k - 1];
			gen_words[k] = INIT_MULT * (prev ^ (prev >> 62)) + word_t'(k);
		end
		gen_index = N_WORDS;
	endfunction

	// In-place regeneration; later words see the already updated early ones.
	function automatic void regenerate_words();
		word_t joined;
		word_t fresh;
		int unsigned k;
		for (k = 0; k < N_WORDS; k++) begin
			joined = (gen_words[k] & HIGH_BITS) | (gen_words[(k + 1) % N_WORDS] & LOW_BITS);
			fresh  = gen_words[(k + MID_OFFSET) % N_WORDS] ^ (joined >> 1);
			if (joined[0]) begin
				fresh = fresh ^ TWIST_POLY;
			end
			gen_words[k] = fresh;
		end
		gen_index = 0;
		n_regens++;
	endfunction

	function automatic word_t next_draw();
		word_t t;
		if (gen_index >= N_WORDS) begin
			regenerate_words();
		end
		t = gen_words[gen_index];
		gen_index++;
		t = t ^ ((t >> 29) & TEMPER_B);
		t = t ^ ((t << 17) & TEMPER_C);
		t = t ^ ((t << 37) & TEMPER_D);
		t = t ^ (t >> 43);
		return t;
	endfunction

	function automatic word_t pick_seed();
		word_t s;
		case ($urandom_range(7))
			0: s = '0;
			1: s = '1;
			2: s = word_t'($urandom_range(255));
			default: s = {$urandom, $urandom};
		endcase
		return s;
	endfunction

	// Offers one item after a random gap and waits for the transfer.
	task automatic send_item(input func_t func, input word_t seed);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= seed;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		n_items++;
		if (func == FUNC_RESEED) begin
			load_seed(seed);
			n_reseeds++;
		end else begin
			draws_due.push_back(next_draw());
		end
	endtask

	// Always advances at least one edge, so the valid is never lowered and
	// raised again within one time step.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (draws_due.size() != 0);
	endtask

	task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
			input int unsigned n_draws, input int unsigned reseed_odds, input bit hold_off);
		int unsigned k;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		send_item(FUNC_RESEED, pick_seed());
		for (k = 0; k < n_draws; k++) begin
			if (hold_off && k == 24) begin
				hold_request = 1'b1;
			end
			if (reseed_odds != 0 && $urandom_range(reseed_odds - 1) == 0) begin
				send_item(FUNC_RESEED, pick_seed());
			end else begin
				send_item(FUNC_DRAW, {$urandom, $urandom});
			end
		end
		wait_drained();
	endtask

	// Output side: random back-pressure, or a long hold-off when asked for.
	initial begin
		int unsigned hold_left;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (draws_due.size() == 0) begin
				$display("%0t: random_value transfer %h with no draw outstanding",
					$time, m_axis_tdata);
				mismatches++;
			end else begin
				n_checked++;
				if (m_axis_tdata !== draws_due[0]) begin
					$display("%0t: random_value expected %h, actual %h",
						$time, draws_due[0], m_axis_tdata);
					mismatches++;
				end
				void'(draws_due.pop_front());
			end
		end
	end

	initial begin
		int unsigned row;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = FUNC_DRAW;
		hold_request  = 1'b0;
		tx_idle_pct   = 28;
		rx_idle_pct   = 76;
		mismatches    = 0;
		n_items       = 0;
		n_reseeds     = 0;
		n_checked     = 0;
		n_regens      = 0;
		for (row = 0; row < N_WORDS; row++) begin
			gen_words[row] = '0;
		end
		gen_index = N_WORDS;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < N_DIRECTED; row++) begin
			send_item(DIRECTED[row].func, DIRECTED[row].seed);
		end
		wait_drained();

		random_phase(28, 76, 150, 30, 1'b0);
		random_phase(76, 28, 150, 30, 1'b0);
		// Long enough to regenerate the state three times from one seed.
		random_phase(0, 0, 630, 0, 1'b1);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d items (%0d reseeds) and checked %0d random words,",
			n_items, n_reseeds, n_checked);
		$display("spanning %0d state regenerations under mixed back-pressure.", n_regens);
		if (mismatches == 0) begin
			$display("** mt64_random_generator: PASSED **");
		end else begin
			$display("** mt64_random_generator: FAILED **");
		end
		$finish;
	end

endmodule
